>>> hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Shared constants and types for the SLIP deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned FrameBufferBytes = 8192;
  localparam int unsigned LenW             = 14;
  localparam int unsigned LenMax           = (1 << LenW) - 1;
  localparam logic [LenW-1:0] LimitCap =
    LenW'((FrameBufferBytes > LenMax) ? LenMax : FrameBufferBytes);
  localparam logic [LenW-1:0] MaxLengthReset = 14'd8192;

  localparam logic [7:0] FlagByte = 8'hC0;
  localparam logic [7:0] EscByte  = 8'hDB;
  localparam logic [7:0] EscFlag  = 8'hDC;
  localparam logic [7:0] EscEsc   = 8'hDD;

  // Deframer phase codes. The fourth code behaves as hunting.
  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhSkip = 2'd1;
  localparam logic [1:0] PhData = 2'd2;

  typedef struct packed {
    logic [1:0]      phase;
    logic            escape_pending;
    logic [LenW-1:0] byte_count;
    logic            dropped_flag;
  } state_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            is_frame_end;
    logic [LenW-1:0] frame_length;
    logic            overflow;
    logic            last_of_run;
  } result_t;

endpackage

>>> hdl/slip_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Streaming SLIP deframer: one received byte per beat in, decoded bytes and
// end-of-frame beats out.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the rx channel while ready.
// Each byte is registered, then decoded against the deframer state once the
// result queue has room, and its zero, one or two results enter the four-entry
// queue; the input stays ready as long as the queue holds at most two results,
// so with the output taken every cycle a byte is accepted every cycle, and a
// result passes through the input register and the queue on its way out. An
// escape followed by an ordinary byte or by the closing flag yields two results,
// and only then does the one-result-per-cycle output set the pace.
// End-of-frame beats carry the kept length and an overflow flag for bytes
// dropped beyond max_length (clamped to 1..8192). The user must write
// max_length only while the block is idle; the block does not enforce it.
module slip_frame_decoder_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sfd_pkg::LenW-1:0]   cfg_wdata_i,
  input  logic                       rx_valid_i,
  output logic                       rx_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       is_frame_end_o,
  output logic [sfd_pkg::LenW-1:0]   frame_length_o,
  output logic                       overflow_o,
  output logic                       last_of_run_o
);

  logic [sfd_pkg::LenW-1:0] max_length_q;
  logic [sfd_pkg::LenW-1:0] limit;
  logic                     in_valid_q;
  logic [7:0]               in_byte_q;
  sfd_pkg::state_t          state_q, state_d, state_next;
  logic [1:0]               res_count;
  logic [1:0]               push_count;
  sfd_pkg::result_t         res0, res1, head;
  logic                     room;
  logic                     advance;

  always_comb begin
    limit = (max_length_q > sfd_pkg::LimitCap) ? sfd_pkg::LimitCap : max_length_q;
    if (limit == '0) begin
      limit = sfd_pkg::LenW'(1);
    end
  end

  assign advance    = in_valid_q && room;
  assign rx_ready_o = !in_valid_q || room;
  assign state_d    = advance ? state_next : state_q;
  assign push_count = advance ? res_count : 2'd0;

  sfd_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .limit_i (limit),
    .state_o (state_next),
    .count_o (res_count),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  sfd_out_fifo u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .push0_i      (res0),
    .push1_i      (res1),
    .room_o       (room),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .data_o       (head)
  );

  assign out_byte_o     = head.out_byte;
  assign is_frame_end_o = head.is_frame_end;
  assign frame_length_o = head.frame_length;
  assign overflow_o     = head.overflow;
  assign last_of_run_o  = head.last_of_run;

  always_ff @(posedge clk_i) begin
    if (rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= sfd_pkg::MaxLengthReset;
      in_valid_q   <= 1'b0;
      state_q      <= '{phase: sfd_pkg::PhHunt, escape_pending: 1'b0,
                        byte_count: '0, dropped_flag: 1'b0};
    end else begin
      if (cfg_we_i) begin
        max_length_q <= cfg_wdata_i;
      end
      if (rx_ready_o) begin
        in_valid_q <= rx_valid_i;
      end
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/sfd_decode.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder step logic
// Decodes one received byte against the current deframer state and yields up
// to two results and the next state.
// ----------------------------------------------------------------------------
module sfd_decode (
  input  sfd_pkg::state_t            state_i,
  input  logic [7:0]                 byte_i,
  input  logic [sfd_pkg::LenW-1:0]   limit_i,
  output sfd_pkg::state_t            state_o,
  output logic [1:0]                 count_o,
  output sfd_pkg::result_t           res0_o,
  output sfd_pkg::result_t           res1_o
);

  always_comb begin
    sfd_pkg::state_t  st;
    sfd_pkg::result_t r0;
    sfd_pkg::result_t r1;
    logic [1:0]       n;
    logic             do_keep;
    logic             do_plain;
    logic [7:0]       kb;

    st       = state_i;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;
    do_keep  = 1'b0;
    do_plain = 1'b0;
    kb       = sfd_pkg::EscByte;

    case (st.phase)
      sfd_pkg::PhSkip: begin
        if (byte_i != sfd_pkg::FlagByte) begin
          st.phase          = sfd_pkg::PhData;
          st.escape_pending = 1'b0;
          do_plain          = 1'b1;
        end
      end
      sfd_pkg::PhData: begin
        if (st.escape_pending) begin
          st.escape_pending = 1'b0;
          do_keep           = 1'b1;
          if (byte_i == sfd_pkg::EscFlag) begin
            kb = sfd_pkg::FlagByte;
          end else if (byte_i != sfd_pkg::EscEsc) begin
            // An escape before an ordinary byte passes through; the byte is
            // then handled as fresh payload.
            do_plain = 1'b1;
          end
        end else begin
          do_plain = 1'b1;
        end
      end
      default: begin
        st.phase = sfd_pkg::PhHunt;
        if (byte_i == sfd_pkg::FlagByte) begin
          st.phase          = sfd_pkg::PhSkip;
          st.escape_pending = 1'b0;
          st.byte_count     = '0;
          st.dropped_flag   = 1'b0;
        end
      end
    endcase

    // Escaped byte: only ever the first result of the step.
    if (do_keep) begin
      if (st.byte_count < limit_i) begin
        r0.out_byte   = kb;
        n             = 2'd1;
        st.byte_count = st.byte_count + sfd_pkg::LenW'(1);
      end else begin
        st.dropped_flag = 1'b1;
      end
    end

    if (do_plain) begin
      if (byte_i == sfd_pkg::FlagByte) begin
        if (n == 2'd0) begin
          r0.is_frame_end = 1'b1;
          r0.frame_length = st.byte_count;
          r0.overflow     = st.dropped_flag;
        end else begin
          r1.is_frame_end = 1'b1;
          r1.frame_length = st.byte_count;
          r1.overflow     = st.dropped_flag;
        end
        n                 = n + 2'd1;
        st.phase          = sfd_pkg::PhHunt;
        st.escape_pending = 1'b0;
        st.byte_count     = '0;
        st.dropped_flag   = 1'b0;
      end else if (byte_i == sfd_pkg::EscByte) begin
        st.escape_pending = 1'b1;
      end else if (st.byte_count < limit_i) begin
        if (n == 2'd0) begin
          r0.out_byte = byte_i;
        end else begin
          r1.out_byte = byte_i;
        end
        n             = n + 2'd1;
        st.byte_count = st.byte_count + sfd_pkg::LenW'(1);
      end else begin
        st.dropped_flag = 1'b1;
      end
    end

    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end

    state_o = st;
    count_o = n;
    res0_o  = r0;
    res1_o  = r1;
  end

endmodule

>>> hdl/sfd_out_fifo.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder result queue
// Four-entry queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module sfd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_count_i,
  input  sfd_pkg::result_t push0_i,
  input  sfd_pkg::result_t push1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output sfd_pkg::result_t data_o
);

  sfd_pkg::result_t entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;
  logic [1:0] wr_next;

  assign valid_o = (count_q != 3'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // Room for a worst-case step, judged from registered fill only.
  assign room_o  = (count_q <= 3'd2);
  assign wr_next = wr_ptr_q + 2'd1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_count_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_count_i} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push0_i;
    end
    if (push_count_i == 2'd2) begin
      entry_q[wr_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hdl/sfd_checker.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [7:0]               out_byte_o,
  input logic                     is_frame_end_o,
  input logic [sfd_pkg::LenW-1:0] frame_length_o,
  input logic                     overflow_o
);

  // A stalled result beat must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  // Data beats carry no length or overflow.
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_frame_end_o |-> frame_length_o == '0 && !overflow_o)
    else $error("data beat carries frame status");

  // End-of-frame beats carry no byte.
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_frame_end_o |-> out_byte_o == 8'h00)
    else $error("end-of-frame beat carries a byte");

  // The kept length never exceeds the frame buffer.
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_frame_end_o |-> frame_length_o <= sfd_pkg::LimitCap)
    else $error("frame length beyond buffer size");

endmodule

bind slip_frame_decoder_unit sfd_checker u_sfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .is_frame_end_o (is_frame_end_o),
  .frame_length_o (frame_length_o),
  .overflow_o     (overflow_o)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// SLIP frame decoder testbench
// Drives received bytes into the deframer and checks every decoded beat. A
// short table of directed bytes comes first. Random frames with valid and broken
// escapes, noise and several frame limits follow. A reference predictor in
// the bench computes the expected beats. Both sides of the stream idle at
// random, and once the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned RandomBytes = 550;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct {
    row_kind_e                kind;
    logic [sfd_pkg::LenW-1:0] value;
    row_check_e               check;
    sfd_pkg::result_t         beat;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [sfd_pkg::LenW-1:0] cfg_wdata_i;
  logic                     rx_valid_i;
  logic                     rx_ready_o;
  logic [7:0]               rx_byte_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [7:0]               out_byte_o;
  logic                     is_frame_end_o;
  logic [sfd_pkg::LenW-1:0] frame_length_o;
  logic                     overflow_o;
  logic                     last_of_run_o;

  // Deframer state as the bench sees it.
  logic [1:0]               dec_phase   = sfd_pkg::PhHunt;
  logic                     dec_escape  = 1'b0;
  logic [sfd_pkg::LenW-1:0] dec_count   = '0;
  logic                     dec_dropped = 1'b0;
  logic [sfd_pkg::LenW-1:0] dec_max_len = sfd_pkg::MaxLengthReset;

  sfd_pkg::result_t step_beats[2];
  int               step_n;
  sfd_pkg::result_t beats_due[$];
  int               errors = 0;
  int unsigned      cycle_count = 0;
  int               src_idle_max = 12;
  int               sink_idle_max = 12;
  int               hold_requests = 0;
  int               holds_done = 0;
  int               bytes_sent = 0;

  slip_frame_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_frame_end_o (is_frame_end_o),
    .frame_length_o (frame_length_o),
    .overflow_o     (overflow_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic sfd_pkg::result_t make_beat(logic [7:0] b, logic fin,
                                                 logic [sfd_pkg::LenW-1:0] len,
                                                 logic ovf, logic last);
    sfd_pkg::result_t r;
    r.out_byte     = b;
    r.is_frame_end = fin;
    r.frame_length = len;
    r.overflow     = ovf;
    r.last_of_run  = last;
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_kind_e k, logic [sfd_pkg::LenW-1:0] v,
                                       row_check_e c, sfd_pkg::result_t r);
    stim_row_t row;
    row.kind  = k;
    row.value = v;
    row.check = c;
    row.beat  = r;
    return row;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b, row_check_e c, sfd_pkg::result_t r);
    return mk_row(ROW_BYTE, sfd_pkg::LenW'(b), c, r);
  endfunction

  // A register value of zero still keeps one byte, and the buffer caps the rest.
  function automatic logic [sfd_pkg::LenW-1:0] frame_limit();
    logic [sfd_pkg::LenW-1:0] lim;
    lim = dec_max_len;
    if (lim > sfd_pkg::LimitCap) lim = sfd_pkg::LimitCap;
    if (lim == '0) lim = sfd_pkg::LenW'(1);
    return lim;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (dec_count < frame_limit()) begin
      step_beats[step_n] = make_beat(b, 1'b0, '0, 1'b0, 1'b0);
      step_n++;
      dec_count++;
    end else begin
      dec_dropped = 1'b1;
    end
  endfunction

  function automatic void close_frame();
    step_beats[step_n] = make_beat(8'h00, 1'b1, dec_count, dec_dropped, 1'b0);
    step_n++;
    dec_count   = '0;
    dec_dropped = 1'b0;
    dec_escape  = 1'b0;
    dec_phase   = sfd_pkg::PhHunt;
  endfunction

  function automatic void payload_byte(logic [7:0] b);
    if (b == sfd_pkg::FlagByte) begin
      close_frame();
    end else if (b == sfd_pkg::EscByte) begin
      dec_escape = 1'b1;
    end else begin
      keep_byte(b);
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    step_n = 0;
    if (dec_phase == sfd_pkg::PhSkip) begin
      if (b != sfd_pkg::FlagByte) begin
        dec_phase  = sfd_pkg::PhData;
        dec_escape = 1'b0;
        payload_byte(b);
      end
    end else if (dec_phase == sfd_pkg::PhData) begin
      if (dec_escape) begin
        dec_escape = 1'b0;
        if (b == sfd_pkg::EscFlag) begin
          keep_byte(sfd_pkg::FlagByte);
        end else if (b == sfd_pkg::EscEsc) begin
          keep_byte(sfd_pkg::EscByte);
        end else begin
          // A broken escape passes the escape byte, then decodes b afresh.
          keep_byte(sfd_pkg::EscByte);
          payload_byte(b);
        end
      end else begin
        payload_byte(b);
      end
    end else begin
      dec_phase = sfd_pkg::PhHunt;
      if (b == sfd_pkg::FlagByte) begin
        dec_phase   = sfd_pkg::PhSkip;
        dec_escape  = 1'b0;
        dec_count   = '0;
        dec_dropped = 1'b0;
      end
    end
    if (step_n > 0) step_beats[step_n-1].last_of_run = 1'b1;
  endfunction

  // Entered at the step where the previous beat was taken, with rx_valid_i
  // still high; a zero gap keeps it high for the next byte.
  task automatic send_byte(logic [7:0] b, row_check_e check, sfd_pkg::result_t typed);
    int gap;
    gap = $urandom_range(src_idle_max);
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
    deframe_byte(b);
    if (check == CHK_ONE) begin
      beats_due.push_back(typed);
    end else if (check == CHK_MODEL) begin
      for (int i = 0; i < step_n; i++) beats_due.push_back(step_beats[i]);
    end
  endtask

  task automatic put(logic [7:0] b);
    send_byte(b, CHK_MODEL, '0);
  endtask

  // The last byte taken may yield nothing, so a few cycles pass after the
  // final expected beat before the register is touched.
  task automatic settle_and_write(logic [sfd_pkg::LenW-1:0] v);
    rx_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    dec_max_len = v;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_frame(int most_tokens);
    logic [7:0] b;
    int         pick;
    put(sfd_pkg::FlagByte);
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) put(sfd_pkg::FlagByte);
    repeat ($urandom_range(most_tokens, 1)) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        put(sfd_pkg::EscByte);
        put(sfd_pkg::EscFlag);
      end else if (pick < 20) begin
        put(sfd_pkg::EscByte);
        put(sfd_pkg::EscEsc);
      end else if (pick < 30) begin
        b = 8'($urandom);
        put(sfd_pkg::EscByte);
        put(b);
        if (b == sfd_pkg::FlagByte) return;
      end else if (pick < 33) begin
        put(sfd_pkg::EscByte);
        put(sfd_pkg::FlagByte);
        return;
      end else begin
        do b = 8'($urandom); while (b == sfd_pkg::FlagByte || b == sfd_pkg::EscByte);
        put(b);
      end
    end
    put(sfd_pkg::FlagByte);
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : sink
    int               stall;
    sfd_pkg::result_t got;
    sfd_pkg::result_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds_done < hold_requests) begin
        stall = HoldCycles;
        holds_done++;
      end else begin
        stall = $urandom_range(sink_idle_max);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{out_byte_o, is_frame_end_o, frame_length_o, overflow_o, last_of_run_o};
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: beat with none expected: byte=%02h end=%0b len=%0d ovf=%0b last=%0b",
                 $time, got.out_byte, got.is_frame_end, got.frame_length, got.overflow,
                 got.last_of_run);
      end else begin
        want = beats_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: beat mismatch, expected byte=%02h end=%0b len=%0d ovf=%0b last=%0b",
                   $time, want.out_byte, want.is_frame_end, want.frame_length,
                   want.overflow, want.last_of_run);
          $display("%0t:                  actual byte=%02h end=%0b len=%0d ovf=%0b last=%0b",
                   $time, got.out_byte, got.is_frame_end, got.frame_length, got.overflow,
                   got.last_of_run);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t                rows[$];
    logic [sfd_pkg::LenW-1:0] cfg;
    int                       phase_idx;
    int                       tokens;
    int                       frames;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= '0;

    // Default limit: hunting, repeated flags, byte extremes and every escape form.
    rows.push_back(byte_row(8'h41, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_NONE, '0));
    rows.push_back(byte_row(8'h00, CHK_ONE, make_beat(8'h00, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(8'hFF, CHK_ONE, make_beat(8'hFF, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::EscFlag, CHK_ONE,
                            make_beat(sfd_pkg::FlagByte, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::EscEsc, CHK_ONE,
                            make_beat(sfd_pkg::EscByte, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(8'h55, CHK_MODEL, '0));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_ONE,
                            make_beat(sfd_pkg::EscByte, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(8'h7E, CHK_MODEL, '0));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_MODEL, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_NONE, '0));
    rows.push_back(byte_row(8'h12, CHK_ONE, make_beat(8'h12, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_ONE,
                            make_beat(8'h00, 1'b1, sfd_pkg::LenW'(1), 1'b0, 1'b1)));
    // A zero limit keeps one byte; the rest are dropped and flagged.
    rows.push_back(mk_row(ROW_CFG, 14'd0, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_NONE, '0));
    rows.push_back(byte_row(8'h01, CHK_ONE, make_beat(8'h01, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(byte_row(8'h02, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::EscByte, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::EscFlag, CHK_NONE, '0));
    rows.push_back(byte_row(sfd_pkg::FlagByte, CHK_ONE,
                            make_beat(8'h00, 1'b1, sfd_pkg::LenW'(1), 1'b1, 1'b1)));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle_and_write(rows[i].value);
      end else begin
        send_byte(rows[i].value[7:0], rows[i].check, rows[i].beat);
      end
    end

    phase_idx = 0;
    while (bytes_sent < RandomBytes) begin
      case ($urandom_range(6))
        0:       cfg = 14'd0;
        1:       cfg = 14'd1;
        2:       cfg = sfd_pkg::LenW'(sfd_pkg::LenMax);
        3:       cfg = sfd_pkg::MaxLengthReset;
        4:       cfg = sfd_pkg::LenW'($urandom_range(sfd_pkg::LenMax));
        default: cfg = sfd_pkg::LenW'($urandom_range(24, 2));
      endcase
      settle_and_write(cfg);
      src_idle_max  = ($urandom_range(3) == 0) ? 0 : 12;
      sink_idle_max = ($urandom_range(3) == 0) ? 0 : 12;
      if (phase_idx == 1) begin
        // Back-to-back bytes against a stalled output fill the block.
        hold_requests++;
        src_idle_max = 0;
      end
      tokens = (cfg < 2) ? 5 : (cfg <= 24) ? int'(cfg) + 4 : 16;
      frames = $urandom_range(6, 3);
      for (int f = 0; f < frames && bytes_sent < RandomBytes; f++) begin
        repeat ($urandom_range(3)) send_byte(8'($urandom), CHK_MODEL, '0);
        send_frame(tokens);
      end
      phase_idx++;
    end

    rx_valid_i <= 1'b0;
    for (int i = 0; i < 2000 && beats_due.size() != 0; i++) @(posedge clk_i);
    if (beats_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
